// ----- hw/rtl/pacc_pkg.sv -----
// Shared types, widths and constants for the PI angle controller.
package pacc_pkg;

  // Field widths
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TGT_W      = 21;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TI_W       = 16;
  localparam int unsigned DRV_W      = 10;
  localparam int unsigned ANG_W      = 20;
  localparam int unsigned INTEG_W    = 48;

  // Angle scaling: 360 degrees in 1/256-degree units
  localparam int unsigned ANGLE_SCALE = 360 * 256;
  localparam int unsigned SCALE_W     = 17;
  localparam int unsigned ANG_DIV_W   = CNT_W + SCALE_W;

  // Datapath widths
  localparam int unsigned ERR_W       = TGT_W + 1;
  localparam int unsigned PE_W        = GAIN_W + ERR_W;
  localparam int unsigned MUL_BITS    = TIME_W;
  localparam int unsigned MUL_LEN_W   = $clog2(MUL_BITS + 1);
  localparam int unsigned MUL_ACC_W   = ERR_W + TIME_W;
  localparam int unsigned MUL_MC_W    = PE_W;
  localparam int unsigned SUM_W       = MUL_ACC_W + 1;
  localparam int unsigned INTEG_SHIFT = 8;
  localparam int unsigned NUM_W       = INTEG_W + INTEG_SHIFT + 1;
  localparam int unsigned DEN_SHIFT   = 16;
  localparam int unsigned QUO_W       = NUM_W - DEN_SHIFT;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TGT_W;

  // Reset values and parameter defaults
  localparam int unsigned DEF_GAIN            = 256;
  localparam int unsigned DEF_TI              = 1000;
  localparam int unsigned DEF_COUNTS_PER_TURN = 9600;
  localparam int unsigned DEF_DRIVE_LIMIT     = 400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE  = 2'd0,
    CFG_PROP_GAIN     = 2'd1,
    CFG_INTEGRAL_TIME = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_IMUL_GO,
    ST_IMUL,
    ST_PMUL_GO,
    ST_PMUL,
    ST_TMUL_GO,
    ST_TMUL,
    ST_DIV_GO,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Command to the serial multiplier
  typedef struct packed {
    logic                 start;
    logic [MUL_LEN_W-1:0] len;
  } mul_cmd_t;

endpackage

// ----- hw/rtl/pacc_if.sv -----
// Request and result channel interfaces of the PI angle controller.
interface pacc_in_if import pacc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  encoder_count;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output encoder_count, output time_ms, input ready);
  modport sink   (input valid, input encoder_count, input time_ms, output ready);
endinterface

interface pacc_out_if import pacc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive;
  logic                    clamped;
  logic [ANG_W-1:0]        angle_now;

  modport source (output valid, output drive, output clamped, output angle_now,
                  input ready);
  modport sink   (input valid, input drive, input clamped, input angle_now,
                  output ready);
endinterface

// ----- hw/rtl/pacc_sdiv.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module pacc_sdiv
  import pacc_pkg::*;
#(
  parameter int unsigned N_W = QUO_W,
  parameter int unsigned D_W = TI_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quo_o,
  output logic [D_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(N_W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [N_W-1:0] num_q;
  logic [N_W-1:0] quo_q;
  logic [D_W-1:0] rem_q;
  logic [D_W-1:0] div_q;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial = {rem_q, num_q[N_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[N_W-2:0], 1'b0};
      rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_q <= {quo_q[N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/pacc_smul.sv -----
// Bit-serial shift-add multiplier, multiplier bits taken MSB first.
module pacc_smul
  import pacc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_cmd_t             cmd_i,
  input  logic [MUL_MC_W-1:0]  mcand_i,
  input  logic [MUL_BITS-1:0]  mplier_i,
  output logic                 done_o,
  output logic [MUL_ACC_W-1:0] prod_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_LEN_W-1:0] cnt_q, cnt_d;
  logic [MUL_MC_W-1:0]  mcand_q;
  logic [MUL_BITS-1:0]  bits_q;
  logic [MUL_ACC_W-1:0] acc_q;
  logic [MUL_ACC_W-1:0] mc_ext;

  assign mc_ext = {{(MUL_ACC_W-MUL_MC_W){mcand_q[MUL_MC_W-1]}}, mcand_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.len;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_LEN_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Double the partial product, add the multiplicand on a one bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q <= mcand_i;
      bits_q  <= mplier_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      bits_q <= {bits_q[MUL_BITS-2:0], 1'b0};
      acc_q  <= {acc_q[MUL_ACC_W-2:0], 1'b0} + (bits_q[MUL_BITS-1] ? mc_ext : '0);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- hw/rtl/pi_angle_controller_clamped_core.sv -----
// PI angle controller with clamped drive: sequencer, datapath and result register.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+-----------------------------------
//  sample_i   | in  | valid / ready      | encoder_count[15:0], time_ms[31:0]
//  result_o   | out | valid / ready      | drive[9:0] signed, clamped, angle_now[19:0]
//  cfg port   | in  | cfg_we_i (no wait) | cfg_index_i[1:0], cfg_wdata_i[20:0]
//
// From acceptance to a loaded result, a request runs the bit-serial units in turn:
// a 33-step angle divide, 32 + 16 + 16 shift-add multiply steps and a 41-step
// drive divide, with sequencing states between them.
// One request is in flight at a time; sample_i.ready is high only while idle.
// The result register lets the next request start while a result waits on result_o.
// A stalled result blocks only the final load; everything before it proceeds.
// Reset clears the sequencer, the timestamp, the integral, the windup mark and
// loads the register defaults (target 0, gain 1.0, integral time 1000 ms).
module pi_angle_controller_clamped_core
  import pacc_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
  parameter int unsigned DRIVE_LIMIT     = DEF_DRIVE_LIMIT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pacc_in_if.sink               sample_i,
  pacc_out_if.source            result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CPT_W = $clog2(COUNTS_PER_TURN + 1);

  localparam logic [ANG_W-1:0] ANGLE_MAX = '1;

  // Configuration registers
  logic [TGT_W-1:0]  target_q;
  logic [GAIN_W-1:0] gain_q;
  logic [TI_W-1:0]   ti_q;
  logic [TI_W-1:0]   ti_eff;

  // Controller state
  logic [TIME_W-1:0]  last_time_q;
  logic [INTEG_W-1:0] integ_q;
  logic               windup_q, windup_d;

  // Sequencer
  state_e state_q, state_d;

  // Per-request working registers
  logic [TIME_W-1:0] elapsed_q;
  logic [ANG_W-1:0]  angle_q;
  logic [ERR_W-1:0]  err_q;
  logic [PE_W-1:0]   pe_q;
  logic              num_neg_q;
  logic [NUM_W-1:0]  num_mag_q;

  // Result register
  logic                    out_valid_q, out_valid_d;
  logic [DRV_W-1:0]        out_drive_q;
  logic                    out_clamped_q;
  logic [ANG_W-1:0]        out_angle_q;

  // Unit handshakes
  logic                 accept;
  logic                 ang_start;
  logic                 ang_done;
  logic [ANG_DIV_W-1:0] ang_dividend;
  logic [ANG_DIV_W-1:0] ang_quo;
  logic [CPT_W-1:0]     ang_rem;
  logic [ANG_W-1:0]     ang_sat;
  logic [ERR_W-1:0]     err_d;

  mul_cmd_t             mul_cmd;
  logic [MUL_MC_W-1:0]  mul_mcand;
  logic [MUL_BITS-1:0]  mul_mplier;
  logic                 mul_done;
  logic [MUL_ACC_W-1:0] mul_prod;

  logic                 drv_start;
  logic                 drv_done;
  logic [QUO_W-1:0]     drv_quo;
  logic [TI_W-1:0]      drv_rem;

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-INTEG_W:0] sum_hi;
  logic [INTEG_W-1:0]   integ_sat;
  logic [NUM_W-1:0]     num;

  logic [QUO_W-1:0]     lim_q;
  logic                 rem_nz;
  logic                 at_lim;
  logic                 over;
  logic [DRV_W-1:0]     mag;
  logic [DRV_W-1:0]     drive_d;
  logic                 out_load;

  assign ti_eff = (ti_q == '0) ? TI_W'(1) : ti_q;

  //--------------------------------------------------------------------------
  // Configuration writes; indexes beyond the list are dropped
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      gain_q   <= GAIN_W'(DEF_GAIN);
      ti_q     <= TI_W'(DEF_TI);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TARGET_ANGLE:  target_q <= cfg_wdata_i[TGT_W-1:0];
        CFG_PROP_GAIN:     gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_INTEGRAL_TIME: ti_q     <= cfg_wdata_i[TI_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Angle: count * 360 * 256 / COUNTS_PER_TURN, bit-serial divide
  //--------------------------------------------------------------------------
  assign ang_dividend = ANG_DIV_W'(sample_i.encoder_count) * ANG_DIV_W'(ANGLE_SCALE);

  pacc_sdiv #(
    .N_W (ANG_DIV_W),
    .D_W (CPT_W)
  ) u_ang_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ang_start),
    .dividend_i (ang_dividend),
    .divisor_i  (CPT_W'(COUNTS_PER_TURN)),
    .done_o     (ang_done),
    .quo_o      (ang_quo),
    .rem_o      (ang_rem)
  );

  // Saturate the angle to its field; the remainder is not needed
  assign ang_sat = (ang_quo > ANG_DIV_W'(ANGLE_MAX)) ? ANGLE_MAX : ang_quo[ANG_W-1:0];
  assign err_d   = {target_q[TGT_W-1], target_q} -
                   {{(ERR_W-ANG_W){1'b0}}, ang_sat};

  //--------------------------------------------------------------------------
  // Shared serial multiplier: err*elapsed, gain*err, then (gain*err)*Ti
  //--------------------------------------------------------------------------
  pacc_smul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  always_comb begin
    mul_mcand  = {{(MUL_MC_W-ERR_W){err_q[ERR_W-1]}}, err_q};
    mul_mplier = elapsed_q;
    case (state_q)
      ST_PMUL_GO: mul_mplier = {gain_q, {(MUL_BITS-GAIN_W){1'b0}}};
      ST_TMUL_GO: begin
        mul_mcand  = pe_q;
        mul_mplier = {ti_eff, {(MUL_BITS-TI_W){1'b0}}};
      end
      default: ;
    endcase
  end

  // Integral update with saturation at the signed 48-bit bounds
  assign sum = {{(SUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q} +
               {{(SUM_W-MUL_ACC_W){mul_prod[MUL_ACC_W-1]}}, mul_prod};
  assign sum_hi = sum[SUM_W-1:INTEG_W-1];

  always_comb begin
    integ_sat = sum[INTEG_W-1:0];
    if ((sum_hi != '0) && (sum_hi != '1)) begin
      integ_sat = {sum[SUM_W-1], {(INTEG_W-1){~sum[SUM_W-1]}}};
    end
  end

  // Numerator over a denominator of 65536*Ti: gain*err*Ti + integral*256
  assign num = {{(NUM_W-MUL_ACC_W){mul_prod[MUL_ACC_W-1]}}, mul_prod} +
               {{(NUM_W-INTEG_W-INTEG_SHIFT){integ_q[INTEG_W-1]}}, integ_q,
                {INTEG_SHIFT{1'b0}}};

  //--------------------------------------------------------------------------
  // Drive: |num| / 65536 / Ti, the low 16 bits dropped first
  //--------------------------------------------------------------------------
  pacc_sdiv #(
    .N_W (QUO_W),
    .D_W (TI_W)
  ) u_drv_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (drv_start),
    .dividend_i (num_mag_q[NUM_W-1:DEN_SHIFT]),
    .divisor_i  (ti_eff),
    .done_o     (drv_done),
    .quo_o      (drv_quo),
    .rem_o      (drv_rem)
  );

  assign lim_q   = QUO_W'(DRIVE_LIMIT);
  assign rem_nz  = (drv_rem != '0) || (num_mag_q[DEN_SHIFT-1:0] != '0);
  assign at_lim  = drv_quo == lim_q;
  // Beyond the limit: larger quotient, or equal quotient with a fraction left
  assign over    = (drv_quo > lim_q) || (at_lim && rem_nz);
  assign mag     = over ? DRV_W'(DRIVE_LIMIT) : drv_quo[DRV_W-1:0];
  assign drive_d = num_neg_q ? (DRV_W'(0) - mag) : mag;

  // Windup mark: set beyond the limit, hold exactly at it, clear inside
  always_comb begin
    windup_d = windup_q;
    if (out_load) begin
      if (over) begin
        windup_d = 1'b1;
      end else if (!at_lim) begin
        windup_d = 1'b0;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    accept        = 1'b0;
    ang_start     = 1'b0;
    drv_start     = 1'b0;
    mul_cmd.start = 1'b0;
    mul_cmd.len   = MUL_LEN_W'(TIME_W);
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        accept    = sample_i.valid;
        ang_start = sample_i.valid;
        if (sample_i.valid) state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        if (ang_done) state_d = ST_IMUL_GO;
      end
      ST_IMUL_GO: begin
        mul_cmd.start = 1'b1;
        state_d       = ST_IMUL;
      end
      ST_IMUL: begin
        if (mul_done) state_d = ST_PMUL_GO;
      end
      ST_PMUL_GO: begin
        mul_cmd.start = 1'b1;
        mul_cmd.len   = MUL_LEN_W'(GAIN_W);
        state_d       = ST_PMUL;
      end
      ST_PMUL: begin
        if (mul_done) state_d = ST_TMUL_GO;
      end
      ST_TMUL_GO: begin
        mul_cmd.start = 1'b1;
        mul_cmd.len   = MUL_LEN_W'(TI_W);
        state_d       = ST_TMUL;
      end
      ST_TMUL: begin
        if (mul_done) state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        drv_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (drv_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  //--------------------------------------------------------------------------
  // Controller state
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      integ_q     <= '0;
      windup_q    <= 1'b0;
    end else begin
      windup_q <= windup_d;
      if (accept) last_time_q <= sample_i.time_ms;
      if ((state_q == ST_IMUL) && mul_done) integ_q <= integ_sat;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) elapsed_q <= sample_i.time_ms - last_time_q;
    if ((state_q == ST_ANGLE) && ang_done) begin
      angle_q <= ang_sat;
      err_q   <= err_d;
    end
    if ((state_q == ST_PMUL) && mul_done) pe_q <= mul_prod[PE_W-1:0];
    if ((state_q == ST_TMUL) && mul_done) begin
      num_neg_q <= num[NUM_W-1];
      num_mag_q <= num[NUM_W-1] ? (NUM_W'(0) - num) : num;
    end
  end

  //--------------------------------------------------------------------------
  // Result register
  //--------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_drive_q   <= drive_d;
      out_clamped_q <= over;
      out_angle_q   <= angle_q;
    end
  end

  assign sample_i.ready     = state_q == ST_IDLE;
  assign result_o.valid     = out_valid_q;
  assign result_o.drive     = out_drive_q;
  assign result_o.clamped   = out_clamped_q;
  assign result_o.angle_now = out_angle_q;

`ifndef NO_ASSERTIONS
  // An accepted request always launches the angle divide
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> state_q == ST_ANGLE)
    else $error("accepted request did not start the angle divide");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !result_o.valid || result_o.ready)
    else $error("result register overwritten while pending");

  // A clamped result carries exactly the limit
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.clamped |->
      (result_o.drive == DRV_W'(DRIVE_LIMIT)) ||
      (result_o.drive == (DRV_W'(0) - DRV_W'(DRIVE_LIMIT))))
    else $error("clamped drive differs from the limit");

  // Clamping marks windup
  a_windup_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && over |=> windup_q)
    else $error("windup mark not set after clamping");
`endif

endmodule

// ----- verif/tb_pi_angle_controller_clamped_core.sv -----
// Self-checking testbench for the clamped PI angle controller core.
module tb_pi_angle_controller_clamped_core;
  import pacc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] ms;
  } encoder_sample_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    clamped;
    logic [ANG_W-1:0]        angle_now;
  } drive_result_t;

  // The one index the register map leaves unused; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam logic signed [TGT_W-1:0] TGT_MAX = TGT_W'((1 <<< (TGT_W - 1)) - 1);
  localparam logic signed [TGT_W-1:0] TGT_MIN = TGT_W'(-(1 <<< (TGT_W - 1)));
  // At gain 1.0 with no integral the drive is error/256, so this error hits the limit.
  localparam logic signed [TGT_W-1:0] EXACT_ERR = TGT_W'(DEF_DRIVE_LIMIT * 256);

  localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint ANG_SAT  = (longint'(1) <<< ANG_W) - 1;
  localparam longint DRV_LIM  = DEF_DRIVE_LIMIT;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 122;
  localparam int LONG_STALL      = 1500;
  localparam int TAIL_CYCLES     = 300;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  pacc_in_if  sample_if ();
  pacc_out_if result_if ();

  pi_angle_controller_clamped_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial forever #2 clk_i = ~clk_i;

  // Controller state mirrored by the testbench, starting from the reset values.
  logic signed [TGT_W-1:0] ctl_target  = '0;
  logic [GAIN_W-1:0]       ctl_gain    = GAIN_W'(DEF_GAIN);
  logic [TI_W-1:0]         ctl_ti      = TI_W'(DEF_TI);
  logic [TIME_W-1:0]       ctl_last_ms = '0;
  longint                  ctl_integ   = 0;
  logic                    ctl_windup  = 1'b0;

  encoder_sample_t samples_todo[$];
  drive_result_t   drives_due[$];
  int unsigned     samples_queued = 0;
  int unsigned     samples_taken  = 0;
  logic [TIME_W-1:0] last_queued_ms = '0;
  int unsigned     mismatches     = 0;

  // Idle knobs and long-stall requests, written only by the stimulus process.
  logic        src_idle_en  = 1'b0;
  logic        snk_idle_en  = 1'b0;
  int unsigned stalls_asked = 0;

  // One controller step: angle from the count, integrate error over the elapsed
  // time with saturation, then the drive as one exact fraction against the limit.
  function automatic drive_result_t step_controller(logic [CNT_W-1:0] cnt,
                                                    logic [TIME_W-1:0] now);
    longint            ang;
    longint            err;
    longint            acc;
    longint            tdiv;
    longint            num;
    longint            den;
    longint            lim;
    longint            drv;
    logic [TIME_W-1:0] dt;
    drive_result_t     r;
    ang = (longint'(cnt) * ANGLE_SCALE) / DEF_COUNTS_PER_TURN;
    if (ang > ANG_SAT) ang = ANG_SAT;
    dt  = now - ctl_last_ms;
    err = longint'(ctl_target) - ang;
    acc = ctl_integ + err * longint'(dt);
    if (acc > INTEG_HI) acc = INTEG_HI;
    if (acc < INTEG_LO) acc = INTEG_LO;
    ctl_integ = acc;
    // A zero integral time acts as one millisecond.
    tdiv = (ctl_ti == '0) ? 1 : longint'(ctl_ti);
    num  = longint'(ctl_gain) * err * tdiv + ctl_integ * 256;
    den  = 65536 * tdiv;
    lim  = DRV_LIM * den;
    r.clamped = 1'b0;
    if (num > lim) begin
      drv = DRV_LIM;
      r.clamped = 1'b1;
      ctl_windup = 1'b1;
    end else if (num < -lim) begin
      drv = -DRV_LIM;
      r.clamped = 1'b1;
      ctl_windup = 1'b1;
    end else begin
      // Truncate toward zero; landing exactly on the limit is not a clamp.
      drv = num / den;
      if (num != lim && num != -lim) ctl_windup = 1'b0;
    end
    ctl_last_ms = now;
    r.drive     = drv[DRV_W-1:0];
    r.angle_now = ang[ANG_W-1:0];
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Sender: take the next request from the queue, then draw its idle gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    encoder_sample_t nxt;
    int unsigned     src_wait;
    if (!rst_ni) begin
      sample_if.valid         <= 1'b0;
      sample_if.encoder_count <= '0;
      sample_if.time_ms       <= '0;
      src_wait = 0;
    end else begin
      // Predict at acceptance so the mirrored state follows the block's order.
      if (sample_if.valid && sample_if.ready) begin
        drives_due.push_back(step_controller(sample_if.encoder_count, sample_if.time_ms));
        samples_taken++;
      end
      // Hold the current request until it is taken.
      if (!sample_if.valid || sample_if.ready) begin
        if (src_wait != 0) begin
          src_wait--;
          sample_if.valid <= 1'b0;
        end else if (samples_todo.size() != 0) begin
          nxt = samples_todo.pop_front();
          sample_if.valid         <= 1'b1;
          sample_if.encoder_count <= nxt.count;
          sample_if.time_ms       <= nxt.ms;
          src_wait = src_idle_en ? $urandom_range(0, 7) : 0;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest prediction, stall at random,
  // and serve long stalls asked for by the stimulus.
  always @(posedge clk_i or negedge rst_ni) begin : check_drives
    drive_result_t want;
    int unsigned   pause;
    int unsigned   snk_wait;
    int unsigned   long_left;
    int unsigned   stalls_served;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      snk_wait      = 0;
      long_left     = 0;
      stalls_served = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (drives_due.size() == 0) begin
          flag_error($sformatf("result with nothing expected: drive %0d clamped %0b angle %0d",
                               result_if.drive, result_if.clamped, result_if.angle_now));
        end else begin
          want = drives_due.pop_front();
          if (result_if.drive !== want.drive || result_if.clamped !== want.clamped ||
              result_if.angle_now !== want.angle_now) begin
            flag_error($sformatf(
              "exp drive %0d clamped %0b angle %0d, got drive %0d clamped %0b angle %0d",
              want.drive, want.clamped, want.angle_now,
              result_if.drive, result_if.clamped, result_if.angle_now));
          end
        end
      end
      if (stalls_served != stalls_asked) begin
        stalls_served = stalls_asked;
        long_left = LONG_STALL;
        result_if.ready <= 1'b0;
      end else if (long_left != 0) begin
        long_left--;
        result_if.ready <= (long_left == 0);
      end else if (result_if.valid && result_if.ready) begin
        pause = snk_idle_en ? $urandom_range(0, 7) : 0;
        snk_wait = pause;
        result_if.ready <= (pause == 0);
      end else if (snk_wait != 0) begin
        snk_wait--;
        result_if.ready <= (snk_wait == 0);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Write one register and mirror it. Only called with the block idle.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_TARGET_ANGLE:  ctl_target = data;
      CFG_PROP_GAIN:     ctl_gain   = data[GAIN_W-1:0];
      CFG_INTEGRAL_TIME: ctl_ti     = data[TI_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_sample(logic [CNT_W-1:0] cnt, logic [TIME_W-1:0] stamp);
    encoder_sample_t s;
    s.count = cnt;
    s.ms    = stamp;
    samples_todo.push_back(s);
    samples_queued++;
    last_queued_ms = stamp;
  endtask

  // Hold until every queued request is accepted and every result has arrived.
  task automatic await_idle();
    @(negedge clk_i);
    while (samples_taken != samples_queued || drives_due.size() != 0) @(negedge clk_i);
  endtask

  // Pull the integral back near zero: one request at count 0 against an extreme
  // target, with an elapsed time sized from the mirrored integral.
  task automatic recenter_integral();
    longint mag;
    mag = (ctl_integ < 0) ? -ctl_integ : ctl_integ;
    cfg_write(CFG_TARGET_ANGLE, (ctl_integ < 0) ? TGT_MAX : TGT_MIN);
    queue_sample('0, ctl_last_ms + TIME_W'(mag / 1048576));
    await_idle();
  endtask

  // Main stimulus: directed corner cases, then randomized phases.
  initial begin : stimulus
    int                      base;
    int                      c;
    int                      kind;
    logic signed [TGT_W-1:0] tgt;
    int unsigned             gain;
    int unsigned             ti;
    logic [TIME_W-1:0]       ms;
    sample_if.valid         = 1'b0;
    sample_if.encoder_count = '0;
    sample_if.time_ms       = '0;
    result_if.ready         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drive exactly at +-limit with no integral yet (first step, zero elapsed),
    // then one unit past it on each side.
    cfg_write(CFG_TARGET_ANGLE, EXACT_ERR);
    queue_sample('0, '0);
    await_idle();
    cfg_write(CFG_TARGET_ANGLE, TGT_W'(EXACT_ERR + 1));
    queue_sample('0, '0);
    await_idle();
    cfg_write(CFG_TARGET_ANGLE, -EXACT_ERR);
    queue_sample('0, '0);
    await_idle();
    cfg_write(CFG_TARGET_ANGLE, TGT_W'(-EXACT_ERR - 1));
    queue_sample('0, '0);
    await_idle();

    // Small errors inside the linear range.
    cfg_write(CFG_TARGET_ANGLE, 21'sd50000);
    queue_sample(16'd5000, 32'd10);
    queue_sample(16'd5300, 32'd25);
    queue_sample(16'd5208, 32'd1000);
    queue_sample(16'd4900, 32'd1003);
    await_idle();

    // Zero gain (upper data bits dropped), zero integral time, maximum target:
    // saturate the integral high, then wrap the timestamp.
    cfg_write(CFG_PROP_GAIN, 21'h1F0000);
    cfg_write(CFG_INTEGRAL_TIME, '0);
    cfg_write(CFG_TARGET_ANGLE, TGT_MAX);
    queue_sample('0, 32'hFFFF_FFFF);
    queue_sample(16'hFFFF, 32'h0000_0010);
    await_idle();

    // Full gain, longest integral time, minimum target: saturate low.
    cfg_write(CFG_PROP_GAIN, 21'h1FFFFF);
    cfg_write(CFG_INTEGRAL_TIME, 21'h00FFFF);
    cfg_write(CFG_TARGET_ANGLE, TGT_MIN);
    queue_sample(16'hFFFF, 32'hFFFF_FFF0);
    queue_sample(16'h5555, 32'hAAAA_AAAA);
    queue_sample(16'hAAAA, 32'h5555_5555);
    await_idle();

    // A write to the unused index must leave every register alone.
    cfg_write(CFG_UNMAPPED, 21'h1FFFFF);
    queue_sample(16'd100, 32'h5555_5560);
    await_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // Phase 0 runs without idling; later phases mix both sides.
      src_idle_en = (ph % 4) != 0;
      snk_idle_en = (ph != 0) && ((ph % 3) != 1);
      recenter_integral();

      base = $urandom_range(0, 65535);
      if ($urandom_range(0, 7) == 0) begin
        tgt = TGT_W'($urandom);
      end else begin
        // Pick a target that one count hits exactly, so that count can take
        // large time jumps without moving the integral.
        tgt = TGT_W'((longint'(base) * ANGLE_SCALE) / DEF_COUNTS_PER_TURN);
      end
      gain = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 1024);
      ti   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(100, 5000);
      cfg_write(CFG_TARGET_ANGLE, tgt);
      cfg_write(CFG_PROP_GAIN, {5'($urandom), 16'(gain)});
      cfg_write(CFG_INTEGRAL_TIME, {5'($urandom), 16'(ti)});

      // Back up the result side for a long stretch while requests keep coming.
      if (ph == 2) begin
        @(negedge clk_i);
        stalls_asked++;
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          c  = base;
          ms = TIME_W'($urandom);
        end else if (kind == 1) begin
          c  = $urandom_range(0, 65535);
          ms = last_queued_ms + TIME_W'($urandom_range(0, 40));
        end else begin
          c = base + int'($urandom_range(0, 64)) - 32;
          if (c < 0) c = 0;
          if (c > 65535) c = 65535;
          ms = last_queued_ms + TIME_W'($urandom_range(0, 40));
        end
        queue_sample(CNT_W'(c), ms);
        // Midway through one phase, pause the sender until everything is back.
        if (ph == 5 && k == ITEMS_PER_PHASE / 2) await_idle();
      end
      await_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
